// ----- hw/rtl/mce_pkg.sv -----
// Shared types and constants for the multiset combination enumerator.
// No dependencies; every other file in hw/rtl except mce_req_if uses this package.
package mce_pkg;

  localparam int MAX_LENGTH_DEF = 16;
  localparam int VALUE_BITS_DEF = 8;
  localparam int RESULT_LIMIT   = 16;

  localparam int LEN_BITS       = 5;
  localparam int MAXV_BITS      = 8;
  localparam int POS_BITS       = 4;
  localparam int COORD_BITS     = 8;
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 8;

  // register indexes on the config port
  localparam logic [CFG_INDEX_BITS-1:0] REG_VECTOR_LENGTH = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_MAX_VALUE     = 2'd1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT,
    ST_EXH
  } state_t;

  // sequencer -> vector unit
  typedef struct packed {
    logic clear;
    logic write;
  } vec_ctl_t;

endpackage

// ----- hw/rtl/mce_req_if.sv -----
// Request channel: valid/ready plus the restart flag.
// Depends on nothing.
interface mce_req_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

// ----- hw/rtl/mce_res_if.sv -----
// Result channel: valid/ready plus one coordinate item.
// Depends on mce_pkg for field widths.
interface mce_res_if;
  logic                             valid;
  logic                             ready;
  logic [mce_pkg::POS_BITS-1:0]     position;
  logic [mce_pkg::COORD_BITS-1:0]   coord_value;
  logic                             end_of_vector;
  logic                             final_vector;
  logic                             exhausted;

  modport source (output valid, output position, output coord_value, output end_of_vector,
                  output final_vector, output exhausted, input ready);
  modport sink   (input valid, input position, input coord_value, input end_of_vector,
                  input final_vector, input exhausted, output ready);
endinterface

// ----- hw/rtl/mce_cfg_if.sv -----
// Configuration write channel: valid/ready, register index and data.
// Depends on mce_pkg for field widths.
interface mce_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [mce_pkg::CFG_INDEX_BITS-1:0] index;
  logic [mce_pkg::CFG_DATA_BITS-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- hw/rtl/multiset_combination_enumerator_core.sv -----
// Top level of the lexicographic multiset combination enumerator.
// Depends on mce_pkg, mce_req_if, mce_res_if, mce_cfg_if and mce_vec_unit.
//
//   channel | dir | payload                                          | item
//   --------+-----+--------------------------------------------------+-----------------------
//   req     | in  | restart                                          | one request
//   res     | out | position, coord_value, end_of_vector,            | one coordinate
//           |     | final_vector, exhausted                          | (or exhausted marker)
//   cfg     | in  | index, data                                      | one register write
//
// Sequence: a request is accepted in idle, then scanned from the last coordinate
//   down, one compare per cycle, until an entry below the max is found; the L
//   coordinates are then emitted, one per cycle while res.ready allows; L is the
//   effective length. An exhausted request goes from idle to the exhausted
//   marker. All compares and increments share the single unit in mce_vec_unit.
// Reset: rst (synchronous) clears the vector, the finished flag and the
//   sequencer; vector_length and max_value come up as 1.
// Stalls: a result waits in the output register while res.ready is low; emission
//   pauses and resumes without loss. req.ready is high only between requests.
module multiset_combination_enumerator_core #(
  parameter int MAX_LENGTH = mce_pkg::MAX_LENGTH_DEF,
  parameter int VALUE_BITS = mce_pkg::VALUE_BITS_DEF
) (
  input logic   clk,
  input logic   rst,
  mce_req_if.sink   req,
  mce_res_if.source res,
  mce_cfg_if.sink   cfg
);

  // only the first RESULT_LIMIT coordinates can ever be used
  localparam int DEPTH = (MAX_LENGTH < mce_pkg::RESULT_LIMIT) ? MAX_LENGTH
                                                               : mce_pkg::RESULT_LIMIT;
  localparam int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // config registers
  logic [mce_pkg::LEN_BITS-1:0]  vec_len;
  logic [mce_pkg::MAXV_BITS-1:0] max_val;

  // sequencer state
  mce_pkg::state_t       state, state_next;
  logic [IW-1:0]         idx, idx_next;
  logic [IW-1:0]         pick, pick_next;
  logic                  found, found_next;
  logic [VALUE_BITS-1:0] vinc, vinc_next;
  logic                  finished, finished_next;

  // vector unit
  mce_pkg::vec_ctl_t     ctl;
  logic [VALUE_BITS-1:0] rd_data;
  logic                  below;
  logic [VALUE_BITS-1:0] rd_inc;
  logic [VALUE_BITS-1:0] top;

  // effective length as the index of the last coordinate
  logic [mce_pkg::LEN_BITS-1:0] len_sat;
  logic [IW-1:0]                last;

  // output register
  logic                           res_valid;
  logic                           slot_free;
  logic                           out_load;
  logic [mce_pkg::POS_BITS-1:0]   pos_next;
  logic [mce_pkg::COORD_BITS-1:0] coord_next;
  logic                           eov_next;
  logic                           fin_next;
  logic                           exh_next;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vec_len <= mce_pkg::LEN_BITS'(1);
      max_val <= mce_pkg::MAXV_BITS'(1);
    end else if (cfg.valid) begin
      if (cfg.index == mce_pkg::REG_VECTOR_LENGTH) begin
        vec_len <= cfg.data[mce_pkg::LEN_BITS-1:0];
      end else if (cfg.index == mce_pkg::REG_MAX_VALUE) begin
        max_val <= cfg.data[mce_pkg::MAXV_BITS-1:0];
      end
    end
  end

  always_comb begin
    if (vec_len == '0) begin
      len_sat = mce_pkg::LEN_BITS'(1);
    end else if (vec_len > mce_pkg::LEN_BITS'(DEPTH)) begin
      len_sat = mce_pkg::LEN_BITS'(DEPTH);
    end else begin
      len_sat = vec_len;
    end
  end

  assign last = IW'(len_sat - mce_pkg::LEN_BITS'(1));
  assign top  = VALUE_BITS'(max_val);

  mce_vec_unit #(
    .DEPTH      (DEPTH),
    .VALUE_BITS (VALUE_BITS),
    .IW         (IW)
  ) u_vec (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ctl),
    .idx     (idx),
    .wr_data (vinc),
    .top     (top),
    .rd_data (rd_data),
    .below   (below),
    .rd_inc  (rd_inc)
  );

  assign slot_free = !res_valid || res.ready;
  assign req.ready = (state == mce_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= mce_pkg::ST_IDLE;
      idx      <= '0;
      pick     <= '0;
      found    <= 1'b0;
      finished <= 1'b0;
    end else begin
      state    <= state_next;
      idx      <= idx_next;
      pick     <= pick_next;
      found    <= found_next;
      finished <= finished_next;
    end
  end

  always_ff @(posedge clk) begin
    vinc <= vinc_next;
  end

  always_comb begin
    state_next    = state;
    idx_next      = idx;
    pick_next     = pick;
    found_next    = found;
    vinc_next     = vinc;
    finished_next = finished;
    ctl           = '0;
    out_load      = 1'b0;
    pos_next      = '0;
    coord_next    = '0;
    eov_next      = 1'b0;
    fin_next      = 1'b0;
    exh_next      = 1'b0;

    case (state)
      mce_pkg::ST_IDLE: begin
        if (req.valid) begin
          if (req.restart) begin
            ctl.clear     = 1'b1;
            finished_next = 1'b0;
          end
          if (finished && !req.restart) begin
            state_next = mce_pkg::ST_EXH;
          end else begin
            state_next = mce_pkg::ST_SCAN;
            idx_next   = last;
            found_next = 1'b0;
          end
        end
      end

      // rightmost entry below the max, one compare per cycle
      mce_pkg::ST_SCAN: begin
        if (below) begin
          found_next = 1'b1;
          pick_next  = idx;
          vinc_next  = rd_inc;
          idx_next   = '0;
          state_next = mce_pkg::ST_EMIT;
        end else if (idx == '0) begin
          state_next = mce_pkg::ST_EMIT;
        end else begin
          idx_next = idx - IW'(1);
        end
      end

      // emit coordinate idx; fill from pick onward in the same pass
      mce_pkg::ST_EMIT: begin
        if (slot_free) begin
          out_load   = 1'b1;
          pos_next   = mce_pkg::POS_BITS'(idx);
          coord_next = mce_pkg::COORD_BITS'(rd_data);
          eov_next   = (idx == last);
          fin_next   = !found;
          if (found && (idx >= pick)) begin
            ctl.write = 1'b1;
          end
          if (idx == last) begin
            if (!found) begin
              finished_next = 1'b1;
            end
            state_next = mce_pkg::ST_IDLE;
          end else begin
            idx_next = idx + IW'(1);
          end
        end
      end

      mce_pkg::ST_EXH: begin
        if (slot_free) begin
          out_load   = 1'b1;
          exh_next   = 1'b1;
          state_next = mce_pkg::ST_IDLE;
        end
      end

      default: begin
        state_next = mce_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (out_load) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      res.position      <= pos_next;
      res.coord_value   <= coord_next;
      res.end_of_vector <= eov_next;
      res.final_vector  <= fin_next;
      res.exhausted     <= exh_next;
    end
  end

  assign res.valid = res_valid;

endmodule

// ----- hw/rtl/mce_vec_unit.sv -----
// Vector store with its single compare/increment unit, read at one index.
// Depends on mce_pkg (vec_ctl_t).
module mce_vec_unit #(
  parameter int DEPTH      = mce_pkg::RESULT_LIMIT,
  parameter int VALUE_BITS = mce_pkg::VALUE_BITS_DEF,
  parameter int IW         = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  input  mce_pkg::vec_ctl_t     ctl,
  input  logic [IW-1:0]         idx,
  input  logic [VALUE_BITS-1:0] wr_data,
  input  logic [VALUE_BITS-1:0] top,
  output logic [VALUE_BITS-1:0] rd_data,
  output logic                  below,
  output logic [VALUE_BITS-1:0] rd_inc
);

  logic [VALUE_BITS-1:0] vec [DEPTH];

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      for (int i = 0; i < DEPTH; i++) begin
        vec[i] <= '0;
      end
    end else if (ctl.write) begin
      vec[idx] <= wr_data;
    end
  end

  assign rd_data = vec[idx];
  assign below   = rd_data < top;
  assign rd_inc  = rd_data + VALUE_BITS'(1);

endmodule

// ----- tb/sv/tb_multiset_combination_enumerator_core.sv -----
// Self-checking testbench for multiset_combination_enumerator_core.
// Depends on mce_pkg and the mce_req_if, mce_res_if and mce_cfg_if interfaces.
// It tracks the enumeration state itself and checks every coordinate item.
module tb_multiset_combination_enumerator_core;

  localparam int VEC_DEPTH   = mce_pkg::MAX_LENGTH_DEF;
  localparam int SETTLE_CYC  = 2 * mce_pkg::RESULT_LIMIT + 8;  // drain time after the last item
  localparam int STALL_CYC   = 200;                            // long receiver hold-off
  localparam int RAND_ITEMS  = 130;

  // indexes that map to no register; writes there must change nothing
  localparam logic [mce_pkg::CFG_INDEX_BITS-1:0] REG_SPARE_A = 2'd2;
  localparam logic [mce_pkg::CFG_INDEX_BITS-1:0] REG_SPARE_B = 2'd3;

  typedef struct packed {
    logic [mce_pkg::POS_BITS-1:0]   position;
    logic [mce_pkg::COORD_BITS-1:0] coord_value;
    logic                           end_of_vector;
    logic                           final_vector;
    logic                           exhausted;
  } coord_item_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  mce_req_if req_ch();
  mce_res_if res_ch();
  mce_cfg_if cfg_ch();

  multiset_combination_enumerator_core u_top (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .res (res_ch),
    .cfg (cfg_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Enumeration state as the block should hold it
  logic [mce_pkg::COORD_BITS-1:0] enum_vec [VEC_DEPTH];
  bit                             enum_done;
  logic [mce_pkg::LEN_BITS-1:0]   cfg_len;
  logic [mce_pkg::MAXV_BITS-1:0]  cfg_max;

  coord_item_t coord_queue [$];    // coordinates still owed by the block
  bit          restart_queue [$];  // requests waiting to be offered

  bit req_hs, res_hs;              // handshakes seen at the last rising edge
  int req_gap, res_wait;
  bit no_idle;                     // set by the sequence for gap-free stretches
  bit stall_armed, hold_active;
  int fail_count;
  int rand_items;

  // One request: optional restart, then either the exhausted marker or the
  // whole current vector, then the lexicographic advance.
  task automatic enumerate_step(input bit restart);
    int          len;
    int          pick;
    int          j;
    bit          found;
    coord_item_t c;
    len = cfg_len;
    if (len == 0) len = 1;
    if (len > mce_pkg::MAX_LENGTH_DEF) len = mce_pkg::MAX_LENGTH_DEF;
    if (len > mce_pkg::RESULT_LIMIT) len = mce_pkg::RESULT_LIMIT;
    found = 1'b0;
    pick  = 0;
    if (restart) begin
      for (j = 0; j < VEC_DEPTH; j++) enum_vec[j] = '0;
      enum_done = 1'b0;
    end
    if (enum_done) begin
      c = '0;
      c.exhausted = 1'b1;
      coord_queue.push_back(c);
    end else begin
      // rightmost entry still below the max; entries above a lowered max
      // count as not below it
      for (j = len - 1; j >= 0; j--) begin
        if (!found && enum_vec[j] < cfg_max) begin
          pick  = j;
          found = 1'b1;
        end
      end
      for (j = 0; j < len; j++) begin
        c.position      = j[mce_pkg::POS_BITS-1:0];
        c.coord_value   = enum_vec[j];
        c.end_of_vector = (j == len - 1);
        c.final_vector  = !found;
        c.exhausted     = 1'b0;
        coord_queue.push_back(c);
      end
      if (found) begin
        c.coord_value = enum_vec[pick] + 1'b1;
        for (j = pick; j < len; j++) enum_vec[j] = c.coord_value;
      end else begin
        enum_done = 1'b1;
      end
    end
  endtask

  // Rising edge: record handshakes, check results, then predict new requests.
  always @(posedge clk) begin
    coord_item_t got, want;
    req_hs = !rst && req_ch.valid && req_ch.ready;
    res_hs = !rst && res_ch.valid && res_ch.ready;
    if (res_hs) begin
      got = '{res_ch.position, res_ch.coord_value, res_ch.end_of_vector,
              res_ch.final_vector, res_ch.exhausted};
      if (coord_queue.size() == 0) begin
        if (fail_count < 10)
          $display("unexpected item: pos %0d value %0d eov %0b final %0b exh %0b",
                   got.position, got.coord_value, got.end_of_vector,
                   got.final_vector, got.exhausted);
        fail_count++;
      end else begin
        want = coord_queue.pop_front();
        if (got !== want) begin
          if (fail_count < 10)
            $display({"mismatch (exp/got): pos %0d/%0d value %0d/%0d eov %0b/%0b ",
                      "final %0b/%0b exh %0b/%0b"},
                     want.position, got.position, want.coord_value, got.coord_value,
                     want.end_of_vector, got.end_of_vector, want.final_vector,
                     got.final_vector, want.exhausted, got.exhausted);
          fail_count++;
        end
      end
    end
    if (req_hs) enumerate_step(req_ch.restart);
  end

  // Request driver: after each accepted item it draws a random idle gap, none while no_idle is set.
  always @(negedge clk) begin
    if (rst) begin
      req_ch.valid   <= 1'b0;
      req_ch.restart <= 1'b0;
      req_gap = 0;
    end else begin
      if (req_hs) req_gap = no_idle ? 0 : $urandom_range(0, 3);
      if (req_ch.valid && !req_hs) begin
        // item still on offer, hold it
      end else if (req_gap != 0) begin
        req_gap--;
        req_ch.valid <= 1'b0;
      end else if (restart_queue.size() != 0) begin
        req_ch.valid   <= 1'b1;
        req_ch.restart <= restart_queue.pop_front();
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // Result sink: a random spell of low ready after each item (none while no_idle is set), or the long hold-off.
  always @(negedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
      res_wait = 0;
    end else begin
      if (res_hs) res_wait = no_idle ? 0 : $urandom_range(0, 3);
      if (hold_active) begin
        res_ch.ready <= 1'b0;
      end else if (res_wait != 0) begin
        res_wait--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  // Long receiver stall, counted here so the sequence can keep offering items.
  initial begin
    hold_active = 1'b0;
    wait (stall_armed);
    @(posedge clk);
    hold_active = 1'b1;
    repeat (STALL_CYC) @(posedge clk);
    hold_active = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // Register write on the config channel; the local copy follows at the handshake.
  task automatic write_reg(input logic [mce_pkg::CFG_INDEX_BITS-1:0] idx,
                           input logic [mce_pkg::CFG_DATA_BITS-1:0] val);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      mce_pkg::REG_VECTOR_LENGTH: cfg_len = val[mce_pkg::LEN_BITS-1:0];
      mce_pkg::REG_MAX_VALUE:     cfg_max = val[mce_pkg::MAXV_BITS-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Idle: nothing queued or offered, every coordinate back, block between requests.
  task automatic wait_idle();
    do @(posedge clk);
    while (restart_queue.size() != 0 || req_ch.valid || coord_queue.size() != 0 ||
           !req_ch.ready);
  endtask

  task automatic push_reqs(input int n, input bit first_restart);
    restart_queue.push_back(first_restart);
    repeat (n - 1) restart_queue.push_back($urandom_range(0, 11) == 0);
  endtask

  initial begin
    int n;
    bit big;
    req_ch.valid   = 1'b0;
    req_ch.restart = 1'b0;
    res_ch.ready   = 1'b0;
    cfg_ch.valid   = 1'b0;
    cfg_ch.index   = '0;
    cfg_ch.data    = '0;
    for (int j = 0; j < VEC_DEPTH; j++) enum_vec[j] = '0;
    enum_done   = 1'b0;
    cfg_len     = 5'd1;
    cfg_max     = 8'd1;
    fail_count  = 0;
    no_idle     = 1'b0;
    stall_armed = 1'b0;
    rand_items  = 0;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    wait_idle();

    // ---- directed part ----
    // reset values (length 1, max 1): [0], [1] final, exhausted, restart
    restart_queue.push_back(1'b0);
    restart_queue.push_back(1'b0);
    restart_queue.push_back(1'b0);
    restart_queue.push_back(1'b1);
    wait_idle();

    // length zero acts as one (upper data bits dropped); max zero: first vector is final
    write_reg(mce_pkg::REG_VECTOR_LENGTH, 8'hE0);
    write_reg(mce_pkg::REG_MAX_VALUE, 8'h00);
    restart_queue.push_back(1'b1);
    restart_queue.push_back(1'b0);
    wait_idle();

    // length 31 saturates to 16, max at 255
    write_reg(mce_pkg::REG_VECTOR_LENGTH, 8'h1F);
    write_reg(mce_pkg::REG_MAX_VALUE, 8'hFF);
    restart_queue.push_back(1'b1);
    restart_queue.push_back(1'b0);
    restart_queue.push_back(1'b0);
    wait_idle();

    // max dropped mid-run below stored entries: stored vector comes out final
    write_reg(mce_pkg::REG_MAX_VALUE, 8'h00);
    restart_queue.push_back(1'b0);
    restart_queue.push_back(1'b0);
    wait_idle();

    // spare indexes must be ignored
    write_reg(REG_SPARE_A, 8'hA5);
    write_reg(REG_SPARE_B, 8'h5A);
    write_reg(mce_pkg::REG_VECTOR_LENGTH, 8'd3);
    write_reg(mce_pkg::REG_MAX_VALUE, 8'd5);
    restart_queue.push_back(1'b1);
    restart_queue.push_back(1'b0);
    restart_queue.push_back(1'b0);
    wait_idle();
    // shrink then regrow the length mid-run; the hidden entry is kept
    write_reg(mce_pkg::REG_VECTOR_LENGTH, 8'd2);
    restart_queue.push_back(1'b0);
    wait_idle();
    write_reg(mce_pkg::REG_VECTOR_LENGTH, 8'd3);
    restart_queue.push_back(1'b0);
    restart_queue.push_back(1'b0);
    wait_idle();

    // exact maximum length
    write_reg(mce_pkg::REG_VECTOR_LENGTH, 8'h10);
    write_reg(mce_pkg::REG_MAX_VALUE, 8'd1);
    restart_queue.push_back(1'b1);
    restart_queue.push_back(1'b0);
    wait_idle();

    // ---- random phases ----
    // Mostly small lengths and maxima so enumerations run out and exhausted
    // items show up; now and then a large setting. Phases often continue
    // without restart to cover mid-run config changes.
    while (rand_items < RAND_ITEMS) begin
      if (!stall_armed && rand_items >= RAND_ITEMS / 2) begin
        // receiver goes quiet while a burst of long vectors is offered
        no_idle = 1'b0;
        write_reg(mce_pkg::REG_VECTOR_LENGTH, 8'd16);
        write_reg(mce_pkg::REG_MAX_VALUE, 8'hFF);
        stall_armed = 1'b1;
        push_reqs(8, 1'b1);
        rand_items += 8;
        wait_idle();
      end
      big     = ($urandom_range(0, 7) == 0);
      no_idle = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 3) != 0) begin
        n = big ? $urandom_range(0, 31) : $urandom_range(1, 4);
        write_reg(mce_pkg::REG_VECTOR_LENGTH, {3'($urandom_range(0, 7)), 5'(n)});
      end
      if ($urandom_range(0, 3) != 0)
        write_reg(mce_pkg::REG_MAX_VALUE,
                  big ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, 3)));
      if ($urandom_range(0, 9) == 0)
        write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, 8'($urandom));
      n = big ? $urandom_range(2, 5) : $urandom_range(3, 15);
      push_reqs(n, $urandom_range(0, 1));
      rand_items += n;
      wait_idle();
    end

    no_idle = 1'b0;
    wait_idle();
    repeat (SETTLE_CYC) @(posedge clk);
    if (fail_count == 0 && coord_queue.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
